### sv/cng_pkg.sv
// ----------------------------------------------------------------------------
// cng_pkg: shared types and constants for the colored noise generator
// Number formats, shaping coefficients, register indexes and the saturation
// helper used by the datapath and the top level.
// ----------------------------------------------------------------------------
package cng_pkg;

	// Fixed-point format of internal values.
	localparam int FRAC_BITS   = 20;
	localparam int OUT_SCALE   = 32000;
	localparam int DATA_W      = 32;
	localparam int WIDE_W      = 40;
	localparam int OUT_W       = 16;
	localparam int ENV_W       = 16;
	localparam int COEF_W      = 17;
	localparam int SEED_W      = 32;
	localparam int SC_W        = FRAC_BITS + 2;
	localparam int WHITE_SHIFT = 31 - FRAC_BITS;

	// Serial multiplier operand and product widths.
	localparam int A_W       = DATA_W + 1;
	localparam int B_W       = COEF_W;
	localparam int P_W       = A_W + B_W + 1;
	localparam int MUL_CNT_W = $clog2(B_W);
	localparam int MUL_LAST  = B_W - 1;

	localparam int ROUND16 = 1 << 15;
	localparam int ROUND12 = 1 << 11;
	localparam logic signed [DATA_W-1:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

	localparam logic [SEED_W-1:0] SEED_FALLBACK = 32'h9E3779B9;

	// Shaping coefficients, Q16.
	localparam logic [COEF_W-1:0] K_PA_POLE = 17'd65382;
	localparam logic [COEF_W-1:0] K_PA_IN   = 17'd6491;
	localparam logic [COEF_W-1:0] K_PB_POLE = 17'd63111;
	localparam logic [COEF_W-1:0] K_PB_IN   = 17'd19432;
	localparam logic [COEF_W-1:0] K_PC_POLE = 17'd37356;
	localparam logic [COEF_W-1:0] K_PC_IN   = 17'd68989;
	localparam logic [COEF_W-1:0] K_PD_IN   = 17'd12111;
	localparam logic [COEF_W-1:0] K_BR_POLE = 17'd65208;
	localparam logic [COEF_W-1:0] K_BR_IN   = 17'd3277;
	localparam logic [COEF_W-1:0] K_OUT     = COEF_W'(OUT_SCALE);

	// Colour and filter codes.
	localparam logic [1:0] COLOR_PINK  = 2'd1;
	localparam logic [1:0] COLOR_BROWN = 2'd2;
	localparam logic [1:0] FILT_LOW    = 2'd1;
	localparam logic [1:0] FILT_BAND   = 2'd2;

	// Command codes.
	localparam logic CMD_RESTART = 1'b1;

	// Configuration register indexes.
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_COLOR  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FILTER = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LOW    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_HIGH   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SEED   = 3'd4;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef struct packed {
		logic [1:0]        color;
		logic [1:0]        filter;
		logic [COEF_W-1:0] low_coef;
		logic [COEF_W-1:0] high_coef;
		logic [SEED_W-1:0] seed;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic signed [OUT_W-1:0] sample;
		logic              clipped;
	} res_t;

	// Saturate a wide signed value to the 32-bit range.
	function automatic word_t sat32(input wide_t v);
		if (v > 40'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -40'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[DATA_W-1:0];
	endfunction

endpackage

### sv/colored_noise_generator.sv
// ----------------------------------------------------------------------------
// colored_noise_generator: xorshift32 white, pink and brown noise source
// Configuration registers, input and output word handshakes around the
// serial shaping and filtering datapath.
// ----------------------------------------------------------------------------
// Usage
// Input words carry cmd and envelope on in_valid / in_stall; a word is taken
// when in_valid is high and in_stall low. Each input word yields exactly one
// output word (sample, clipped) on out_valid / out_stall.
// A restart word (cmd 1) reloads the generator from the seed register and clears
// every shaping and filter state; its output word is zero.
// A sample word walks its products one by one through a bit-serial
// multiplier of 17 steps. White with no filter is the shortest case;
// pink noise through the band filter is the longest. One word is
// worked on at a time.
// The output register holds a finished word while the receiver stalls, and
// the next input word is taken and worked on meanwhile; its result then
// waits in the datapath until the output register frees.
// Reset clears the registers to their defaults (white, bypass, both pole
// coefficients one, seed zero) and loads the generator with its fallback.
// Configuration is written through cfg_write, cfg_index and cfg_data while
// the block is idle; there is no read-back.
// ----------------------------------------------------------------------------
module colored_noise_generator
	import cng_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [REG_IDX_W-1:0]    cfg_index,
	input  logic [SEED_W-1:0]       cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    cmd,
	input  logic [ENV_W-1:0]        envelope,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] sample,
	output logic                    clipped
);

	cfg_t                    cfg_q;
	res_t                    res;
	logic                    dp_idle;
	logic                    take;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] out_sample_q;
	logic                    out_clip_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color     <= '0;
			cfg_q.filter    <= '0;
			cfg_q.low_coef  <= 17'd65536;
			cfg_q.high_coef <= 17'd65536;
			cfg_q.seed      <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_COLOR:  cfg_q.color     <= cfg_data[1:0];
				REG_FILTER: cfg_q.filter    <= cfg_data[1:0];
				REG_LOW:    cfg_q.low_coef  <= cfg_data[COEF_W-1:0];
				REG_HIGH:   cfg_q.high_coef <= cfg_data[COEF_W-1:0];
				REG_SEED:   cfg_q.seed      <= cfg_data;
				default: ;
			endcase
		end
	end

	cng_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_valid && !in_stall),
		.cmd      (cmd),
		.envelope (envelope),
		.cfg      (cfg_q),
		.take     (take),
		.idle     (dp_idle),
		.res      (res)
	);

	assign in_stall = !dp_idle;

	// Output register: loads a finished word when empty or being drained.
	assign take = res.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_sample_q <= res.sample;
			out_clip_q   <= res.clipped;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = out_sample_q;
	assign clipped   = out_clip_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken without the datapath turning busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled output word dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(sample) && $stable(clipped)))
		else $error("stalled output word changed");

endmodule

### sv/cng_xorshift.sv
// ----------------------------------------------------------------------------
// cng_xorshift: xorshift32 white noise source
// Holds the generator state, steps it on request, reloads it from the seed
// and presents the current state as a centred fixed-point white sample.
// ----------------------------------------------------------------------------
module cng_xorshift
	import cng_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              advance,
	input  logic [SEED_W-1:0] seed,
	output word_t             white
);

	logic [SEED_W-1:0] rng_q;
	logic [SEED_W-1:0] t1, t2, t3;
	word_t             centred;

	// One xorshift step with shifts 13, 17 and 5.
	always_comb begin
		t1 = rng_q ^ (rng_q << 13);
		t2 = t1 ^ (t1 >> 17);
		t3 = t2 ^ (t2 << 5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q <= SEED_FALLBACK;
		end else if (load) begin
			rng_q <= (seed == '0) ? SEED_FALLBACK : seed;
		end else if (advance) begin
			rng_q <= t3;
		end
	end

	// Removing the offset of 2^31 is a flip of the top bit.
	assign centred = {~rng_q[SEED_W-1], rng_q[SEED_W-2:0]};
	assign white   = centred >>> WHITE_SHIFT;

endmodule

### sv/cng_serial_mult.sv
// ----------------------------------------------------------------------------
// cng_serial_mult: bit-serial signed by unsigned multiplier
// Consumes one bit of the unsigned operand per cycle, least significant bit
// first, and shifts the partial product right into a low shift register.
// ----------------------------------------------------------------------------
module cng_serial_mult
	import cng_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [A_W-1:0] a,
	input  logic [B_W-1:0]        b,
	output logic                  done,
	output logic signed [P_W-1:0] product
);

	logic signed [A_W-1:0]   a_q;
	logic [B_W-1:0]          b_q;
	logic signed [A_W:0]     hi_q;
	logic [B_W-1:0]          lo_q;
	logic [MUL_CNT_W-1:0]    cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic signed [A_W+1:0]   sum;

	// Add the multiplicand when the current multiplier bit is set.
	assign sum = (A_W+2)'(hi_q) + (b_q[0] ? (A_W+2)'(a_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == MUL_CNT_W'(MUL_LAST)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand and partial product shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			hi_q <= sum[A_W+1:1];
			lo_q <= {sum[0], lo_q[B_W-1:1]};
			b_q  <= b_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("multiplier started while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("multiplier did not begin after start");

	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(busy_q) && !busy_q))
		else $error("product flagged without a finished run");

endmodule

### sv/cng_datapath.sv
// ----------------------------------------------------------------------------
// cng_datapath: sequencer and filter state of the noise generator
// Steps one word through colour shaping, filtering, envelope and output
// scaling, issuing every product to the shared bit-serial multiplier.
// ----------------------------------------------------------------------------
module cng_datapath
	import cng_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             cmd,
	input  logic [ENV_W-1:0] envelope,
	input  cfg_t             cfg,
	input  logic             take,
	output logic             idle,
	output res_t             res
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RNG   = 3'd1;
	localparam logic [2:0] ST_SEL   = 3'd2;
	localparam logic [2:0] ST_ISSUE = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;
	localparam logic [2:0] ST_POST  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	// Micro-operations.
	localparam logic [3:0] OP_PA1 = 4'd0;
	localparam logic [3:0] OP_PA2 = 4'd1;
	localparam logic [3:0] OP_PB1 = 4'd2;
	localparam logic [3:0] OP_PB2 = 4'd3;
	localparam logic [3:0] OP_PC1 = 4'd4;
	localparam logic [3:0] OP_PC2 = 4'd5;
	localparam logic [3:0] OP_PD  = 4'd6;
	localparam logic [3:0] OP_PX  = 4'd7;
	localparam logic [3:0] OP_BR1 = 4'd8;
	localparam logic [3:0] OP_BR2 = 4'd9;
	localparam logic [3:0] OP_BX  = 4'd10;
	localparam logic [3:0] OP_HI  = 4'd11;
	localparam logic [3:0] OP_LO  = 4'd12;
	localparam logic [3:0] OP_ENV = 4'd13;
	localparam logic [3:0] OP_OUT = 4'd14;

	logic [2:0]              state_q;
	logic [3:0]              op_q;
	logic [ENV_W-1:0]        env_q;
	word_t                   x_q, y_q;
	word_t                   pa_q, pb_q, pc_q, br_q, hi_q, lo_q;
	wide_t                   t0_q, sum_q;
	logic signed [SC_W-1:0]  sc_q;
	logic                    clip_q;
	logic signed [OUT_W-1:0] res_sample_q;
	logic                    res_clip_q;

	word_t                   white;
	logic signed [A_W-1:0]   mul_a;
	logic [B_W-1:0]          mul_b;
	logic                    mul_start;
	logic                    mul_done;
	logic signed [P_W-1:0]   prod;
	logic signed [P_W-1:0]   p_r16, p_r12, q_full;
	wide_t                   r16_w, base, br7;
	word_t                   sum2_sat, scaled, x_new, lo_y;
	logic signed [SC_W-1:0]  sc_new;
	logic                    clip_new;
	logic                    is_mul_op;
	logic [3:0]              filt_op;

	cng_xorshift u_rng (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (start && (cmd == CMD_RESTART)),
		.advance (state_q == ST_RNG),
		.seed    (cfg.seed),
		.white   (white)
	);

	cng_serial_mult u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (prod)
	);

	// Operand selection for the current micro-operation.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (op_q) inside
			OP_PA1: begin
				mul_a = A_W'(pa_q);
				mul_b = K_PA_POLE;
			end
			OP_PA2: begin
				mul_a = A_W'(white);
				mul_b = K_PA_IN;
			end
			OP_PB1: begin
				mul_a = A_W'(pb_q);
				mul_b = K_PB_POLE;
			end
			OP_PB2: begin
				mul_a = A_W'(white);
				mul_b = K_PB_IN;
			end
			OP_PC1: begin
				mul_a = A_W'(pc_q);
				mul_b = K_PC_POLE;
			end
			OP_PC2: begin
				mul_a = A_W'(white);
				mul_b = K_PC_IN;
			end
			OP_PD: begin
				mul_a = A_W'(white);
				mul_b = K_PD_IN;
			end
			OP_BR1: begin
				mul_a = A_W'(br_q);
				mul_b = K_BR_POLE;
			end
			OP_BR2: begin
				mul_a = A_W'(white);
				mul_b = K_BR_IN;
			end
			OP_HI: begin
				mul_a = A_W'(x_q) - A_W'(hi_q);
				mul_b = cfg.high_coef;
			end
			OP_LO: begin
				mul_a = A_W'(x_q) - A_W'(lo_q);
				mul_b = cfg.low_coef;
			end
			OP_ENV: begin
				mul_a = A_W'(y_q);
				mul_b = B_W'(env_q);
			end
			OP_OUT: begin
				mul_a = A_W'(sc_q);
				mul_b = K_OUT;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign is_mul_op = (op_q != OP_PX) && (op_q != OP_BX);
	assign mul_start = (state_q == ST_ISSUE) && is_mul_op;

	// Rounding of the product and the accumulate adder.
	always_comb begin
		p_r16 = (prod + P_W'(ROUND16)) >>> 16;
		r16_w = WIDE_W'(p_r16);
		case (op_q) inside
			OP_HI:   base = WIDE_W'(hi_q);
			OP_LO:   base = WIDE_W'(lo_q);
			default: base = t0_q;
		endcase
		sum2_sat = sat32(base + r16_w);
		lo_y = (cfg.filter == FILT_BAND) ?
			sat32(WIDE_W'(hi_q) - WIDE_W'(sum2_sat)) : sum2_sat;
	end

	// Colour outputs and choice of the first filter step.
	always_comb begin
		br7 = (WIDE_W'(br_q) <<< 3) - WIDE_W'(br_q);
		case (op_q) inside
			OP_PX:   x_new = sat32((sum_q + 40'sd2) >>> 2);
			OP_BX:   x_new = sat32((br7 + 40'sd1) >>> 1);
			default: x_new = white;
		endcase
		if (cfg.filter == FILT_LOW) begin
			filt_op = OP_LO;
		end else if (cfg.filter == FILT_BAND) begin
			filt_op = OP_HI;
		end else begin
			filt_op = OP_ENV;
		end
	end

	// Envelope rounding, clamp and output scaling.
	always_comb begin
		p_r12  = (prod + P_W'(ROUND12)) >>> 12;
		scaled = sat32(WIDE_W'(p_r12));
		if (scaled > ONE_FX) begin
			sc_new   = SC_W'(ONE_FX);
			clip_new = 1'b1;
		end else if (scaled < -ONE_FX) begin
			sc_new   = SC_W'(-ONE_FX);
			clip_new = 1'b1;
		end else begin
			sc_new   = SC_W'(scaled);
			clip_new = 1'b0;
		end
		if (prod < 0) begin
			q_full = (prod + P_W'(ONE_FX - 32'sd1)) >>> FRAC_BITS;
		end else begin
			q_full = prod >>> FRAC_BITS;
		end
	end

	// Sequencer and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_ENV;
			pa_q    <= '0;
			pb_q    <= '0;
			pc_q    <= '0;
			br_q    <= '0;
			hi_q    <= '0;
			lo_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (cmd == CMD_RESTART) begin
							pa_q    <= '0;
							pb_q    <= '0;
							pc_q    <= '0;
							br_q    <= '0;
							hi_q    <= '0;
							lo_q    <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RNG;
						end
					end
				end
				ST_RNG: begin
					state_q <= ST_SEL;
				end
				ST_SEL: begin
					if (cfg.color == COLOR_PINK) begin
						op_q <= OP_PA1;
					end else if (cfg.color == COLOR_BROWN) begin
						op_q <= OP_BR1;
					end else begin
						op_q <= filt_op;
					end
					state_q <= ST_ISSUE;
				end
				ST_ISSUE: begin
					state_q <= is_mul_op ? ST_WAIT : ST_POST;
				end
				ST_WAIT: begin
					if (mul_done) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					state_q <= ST_ISSUE;
					unique case (op_q)
						OP_PA1: op_q <= OP_PA2;
						OP_PA2: begin
							pa_q <= sum2_sat;
							op_q <= OP_PB1;
						end
						OP_PB1: op_q <= OP_PB2;
						OP_PB2: begin
							pb_q <= sum2_sat;
							op_q <= OP_PC1;
						end
						OP_PC1: op_q <= OP_PC2;
						OP_PC2: begin
							pc_q <= sum2_sat;
							op_q <= OP_PD;
						end
						OP_PD:  op_q <= OP_PX;
						OP_PX:  op_q <= filt_op;
						OP_BR1: op_q <= OP_BR2;
						OP_BR2: begin
							br_q <= sum2_sat;
							op_q <= OP_BX;
						end
						OP_BX:  op_q <= filt_op;
						OP_HI: begin
							hi_q <= sum2_sat;
							op_q <= OP_LO;
						end
						OP_LO: begin
							lo_q <= sum2_sat;
							op_q <= OP_ENV;
						end
						OP_ENV: op_q <= OP_OUT;
						OP_OUT: state_q <= ST_DONE;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working values that need no reset.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			env_q        <= envelope;
			res_sample_q <= '0;
			res_clip_q   <= 1'b0;
		end
		if ((state_q == ST_SEL) && (cfg.color != COLOR_PINK)
				&& (cfg.color != COLOR_BROWN)) begin
			x_q <= x_new;
			y_q <= x_new;
		end
		if (state_q == ST_POST) begin
			case (op_q) inside
				OP_PA1, OP_PB1, OP_PC1, OP_BR1: t0_q <= r16_w;
				OP_PD: sum_q <= WIDE_W'(pa_q) + WIDE_W'(pb_q) + WIDE_W'(pc_q) + r16_w;
				OP_PX, OP_BX: begin
					x_q <= x_new;
					y_q <= x_new;
				end
				OP_LO:  y_q <= lo_y;
				OP_ENV: begin
					sc_q   <= sc_new;
					clip_q <= clip_new;
				end
				OP_OUT: begin
					res_sample_q <= q_full[OUT_W-1:0];
					res_clip_q   <= clip_q;
				end
				default: ;
			endcase
		end
	end

	assign idle        = (state_q == ST_IDLE);
	assign res.valid   = (state_q == ST_DONE);
	assign res.sample  = res_sample_q;
	assign res.clipped = res_clip_q;

endmodule

### dv/tb_colored_noise_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_colored_noise_generator: self-checking bench for the colored noise source
// Sends restart and sample words under a sweep of colour, filter, pole and
// seed settings, with random idling on both handshakes and one long output
// hold-off. Every output word is compared with a bit-exact prediction of the
// xorshift source, the shaping, the filters and the envelope scaling.
// ----------------------------------------------------------------------------
module tb_colored_noise_generator;
	import cng_pkg::*;

	localparam logic CMD_SAMPLE      = 1'b0;
	localparam int   PHASES          = 16;
	localparam int   WORDS_PER_PHASE = 118;
	localparam int   HOLD_CYCLES     = 800;
	localparam int   WATCHDOG_LIMIT  = 20000;
	localparam int   SETTLE_CYCLES   = 300;
	localparam int   MAX_REPORTS     = 10;

	// Arithmetic limits and rounding terms of the Q11.20 datapath.
	localparam longint INT_MAX    = 64'sd2147483647;
	localparam longint INT_MIN    = -64'sd2147483648;
	localparam longint HALF_RANGE = 64'sd2147483648;
	localparam longint ROUND_Q16  = 64'sd32768;
	localparam longint ENV_ROUND  = 64'sd2048;
	localparam longint UNITY      = 64'sd1 <<< FRAC_BITS;
	localparam longint PCM_SCALE  = 64'sd32000;

	// Shaping coefficients in Q16.
	localparam longint PA_POLE    = 65382;
	localparam longint PA_IN      = 6491;
	localparam longint PB_POLE    = 63111;
	localparam longint PB_IN      = 19432;
	localparam longint PC_POLE    = 37356;
	localparam longint PC_IN      = 68989;
	localparam longint PD_IN      = 12111;
	localparam longint PINK_GAIN  = 16384;
	localparam longint BR_POLE    = 65208;
	localparam longint BR_IN      = 3277;
	localparam longint BROWN_GAIN = 229376;

	typedef struct {
		logic signed [OUT_W-1:0] sample;
		logic                    clipped;
	} noise_word_t;

	// Scoreboard: mirrors the registers and the generator state, predicts
	// each output word and checks the words that come back in order.
	class sample_scoreboard;
		logic [1:0]        color_sel;
		logic [1:0]        filter_sel;
		logic [COEF_W-1:0] low_coef;
		logic [COEF_W-1:0] high_coef;
		logic [SEED_W-1:0] seed;
		logic [31:0]       rng;
		int                pole_a, pole_b, pole_c, brown, lp_low, lp_high;
		noise_word_t       expected_words[$];
		int                errors, checked, restarts, clips;

		function new();
			color_sel  = 2'd0;
			filter_sel = 2'd0;
			low_coef   = 17'd65536;
			high_coef  = 17'd65536;
			seed       = '0;
			rng        = SEED_FALLBACK;
			clear_states();
		endfunction

		function void clear_states();
			pole_a  = 0;
			pole_b  = 0;
			pole_c  = 0;
			brown   = 0;
			lp_low  = 0;
			lp_high = 0;
		endfunction

		function longint clamp32(longint v);
			if (v > INT_MAX) begin
				return INT_MAX;
			end else if (v < INT_MIN) begin
				return INT_MIN;
			end
			return v;
		endfunction

		// Product with a Q16 coefficient, rounded and floored.
		function longint mul16(longint v, longint c);
			return (v * c + ROUND_Q16) >>> 16;
		endfunction

		function int pole_step(int y, int x, longint coef);
			return int'(clamp32(longint'(y) + mul16(longint'(x) - longint'(y), coef)));
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [SEED_W-1:0] data);
			case (idx)
				REG_COLOR:  color_sel  = data[1:0];
				REG_FILTER: filter_sel = data[1:0];
				REG_LOW:    low_coef   = data[COEF_W-1:0];
				REG_HIGH:   high_coef  = data[COEF_W-1:0];
				REG_SEED:   seed       = data;
				default:    ;
			endcase
		endfunction

		// Work out the output word for one accepted input word.
		function void predict_sample(logic c, logic [ENV_W-1:0] env);
			noise_word_t w;
			longint      white, shaped, filt, scaled, sum;
			w.sample  = '0;
			w.clipped = 1'b0;
			if (c == CMD_RESTART) begin
				rng = (seed != 0) ? seed : SEED_FALLBACK;
				clear_states();
				restarts++;
				expected_words.push_back(w);
				return;
			end
			rng ^= rng << 13;
			rng ^= rng >> 17;
			rng ^= rng << 5;
			white = clamp32((longint'({32'd0, rng}) - HALF_RANGE) >>> (31 - FRAC_BITS));

			// Noise colour; the unused code behaves as white.
			if (color_sel == COLOR_PINK) begin
				pole_a = int'(clamp32(mul16(pole_a, PA_POLE) + mul16(white, PA_IN)));
				pole_b = int'(clamp32(mul16(pole_b, PB_POLE) + mul16(white, PB_IN)));
				pole_c = int'(clamp32(mul16(pole_c, PC_POLE) + mul16(white, PC_IN)));
				sum = longint'(pole_a) + longint'(pole_b) + longint'(pole_c)
					+ mul16(white, PD_IN);
				shaped = clamp32(mul16(sum, PINK_GAIN));
			end else if (color_sel == COLOR_BROWN) begin
				brown  = int'(clamp32(mul16(brown, BR_POLE) + mul16(white, BR_IN)));
				shaped = clamp32(mul16(brown, BROWN_GAIN));
			end else begin
				shaped = white;
			end

			// Filter; the unused code behaves as bypass.
			if (filter_sel == FILT_LOW) begin
				lp_low = pole_step(lp_low, int'(shaped), low_coef);
				filt   = lp_low;
			end else if (filter_sel == FILT_BAND) begin
				lp_high = pole_step(lp_high, int'(shaped), high_coef);
				lp_low  = pole_step(lp_low, int'(shaped), low_coef);
				filt    = clamp32(longint'(lp_high) - longint'(lp_low));
			end else begin
				filt = shaped;
			end

			// Envelope, clamp to plus or minus one, then scale to PCM.
			scaled = clamp32((filt * longint'({48'd0, env}) + ENV_ROUND) >>> 12);
			if (scaled > UNITY) begin
				scaled    = UNITY;
				w.clipped = 1'b1;
			end else if (scaled < -UNITY) begin
				scaled    = -UNITY;
				w.clipped = 1'b1;
			end
			w.sample = OUT_W'((scaled * PCM_SCALE) / UNITY);
			if (w.clipped) begin
				clips++;
			end
			expected_words.push_back(w);
		endfunction

		function void check_sample(logic signed [OUT_W-1:0] s, logic cl);
			noise_word_t w;
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("ERROR: output word (sample %0d, clipped %0b) with none expected",
						s, cl);
				end
				return;
			end
			w = expected_words.pop_front();
			checked++;
			if (s !== w.sample || cl !== w.clipped) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("ERROR: word %0d: expected sample %0d clipped %0b, got %0d %0b",
						checked, w.sample, w.clipped, s, cl);
				end
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    cfg_write  = 1'b0;
	logic [REG_IDX_W-1:0]    cfg_index  = '0;
	logic [SEED_W-1:0]       cfg_data   = '0;
	logic                    in_valid   = 1'b0;
	logic                    in_stall;
	logic                    cmd        = 1'b0;
	logic [ENV_W-1:0]        envelope   = '0;
	logic                    out_valid;
	logic                    out_stall  = 1'b0;
	logic signed [OUT_W-1:0] sample;
	logic                    clipped;

	int               send_idle_pct  = 0;
	int               recv_stall_pct = 0;
	logic             hold_request   = 1'b0;
	int               quiet_cycles   = 0;
	sample_scoreboard scoreboard;

	colored_noise_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.envelope  (envelope),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample    (sample),
		.clipped   (clipped)
	);

	// Clock generation.
	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, or one long counted hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Word monitors and the watchdog, sampled at the clock edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				scoreboard.predict_sample(cmd, envelope);
			end
			if (out_valid && !out_stall) begin
				scoreboard.check_sample(sample, clipped);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no word moved for %0d cycles", quiet_cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Offer one input word, with random idle cycles ahead of it.
	task automatic send_word(logic c, logic [ENV_W-1:0] env);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		envelope <= env;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// One register write; the caller lowers the write enable afterwards.
	task automatic put_reg(logic [REG_IDX_W-1:0] idx, logic [SEED_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		scoreboard.write_reg(idx, data);
		@(posedge clk);
	endtask

	// Wait for a clock edge first so that the monitor has noted the last accepted
	// word before the outstanding count is looked at.
	task automatic drain(int extra);
		@(posedge clk);
		while (scoreboard.pending() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Pole coefficient from the extremes and typical cutoffs, with noise
	// in the unused upper bits now and then.
	function automatic logic [SEED_W-1:0] choose_coef(int k);
		logic [COEF_W-1:0] coef;
		case (k % 5)
			0:       coef = 17'd65536;
			1:       coef = 17'd0;
			2:       coef = 17'h1FFFF;
			3:       coef = COEF_W'($urandom_range(8192, 256));
			default: coef = COEF_W'($urandom);
		endcase
		return {($urandom_range(1) != 0) ? 15'($urandom) : 15'd0, coef};
	endfunction

	initial begin
		int                p, i;
		logic              c;
		logic [ENV_W-1:0]  env;
		logic [SEED_W-1:0] seed_word;

		scoreboard = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed words at the reset settings: envelope extremes, unity
		// gain, and restarts with the fallback seed.
		send_word(CMD_SAMPLE, 16'h0000);
		send_word(CMD_SAMPLE, 16'hFFFF);
		send_word(CMD_SAMPLE, 16'h1000);
		send_word(CMD_SAMPLE, 16'h0001);
		send_word(CMD_SAMPLE, 16'h7FFF);
		send_word(CMD_SAMPLE, 16'h8000);
		send_word(CMD_RESTART, 16'hFFFF);
		send_word(CMD_SAMPLE, 16'h1000);
		send_word(CMD_SAMPLE, 16'hFFFF);
		send_word(CMD_RESTART, 16'h0000);
		send_word(CMD_SAMPLE, 16'h2000);
		in_valid <= 1'b0;
		drain(4);

		// Random phases: every colour and filter code, pole extremes, seed
		// extremes, and each idling pattern in turn.
		for (p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 62;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 62;
				end
				default: begin
					send_idle_pct  = 6;
					recv_stall_pct = 6;
				end
			endcase
			case (p % 4)
				0:       seed_word = '0;
				1:       seed_word = 32'hFFFF_FFFF;
				2:       seed_word = 32'd1;
				default: seed_word = $urandom;
			endcase
			put_reg(REG_COLOR, {($urandom_range(1) != 0) ? 30'($urandom) : 30'd0, 2'(p % 4)});
			put_reg(REG_FILTER, {($urandom_range(1) != 0) ? 30'($urandom) : 30'd0,
				2'((p / 4) % 4)});
			put_reg(REG_LOW, choose_coef(p));
			put_reg(REG_HIGH, choose_coef(p + 2));
			put_reg(REG_SEED, seed_word);
			cfg_write <= 1'b0;

			// Odd phases carry the previous shaping state over unchanged.
			if (p % 2 == 0) begin
				send_word(CMD_RESTART, ENV_W'($urandom));
			end
			for (i = 0; i < WORDS_PER_PHASE; i++) begin
				if (p == 4 && i == 30) begin
					hold_request = 1'b1;
				end
				c = ($urandom_range(99) < 4) ? CMD_RESTART : CMD_SAMPLE;
				case ($urandom_range(9))
					0:       env = '0;
					1:       env = '1;
					2, 3:    env = ENV_W'($urandom_range(16'h1800, 16'h0800));
					4:       env = ENV_W'($urandom_range(255));
					default: env = ENV_W'($urandom);
				endcase
				send_word(c, env);
			end
			in_valid <= 1'b0;
			drain(4);
		end

		drain(SETTLE_CYCLES);
		$display("Covered %0d output words (%0d restarts, %0d clipped) over %0d settings,",
			scoreboard.checked, scoreboard.restarts, scoreboard.clips, PHASES + 1);
		$display("with idling, stalls and a long output hold-off; %0d mismatches, %0d missing.",
			scoreboard.errors, scoreboard.pending());
		if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
